// ===== src/ixfec_pkg.sv =====
package ixfec_pkg;
  localparam logic [1:0] FUNC_DATA  = 2'd0;
  localparam logic [1:0] FUNC_LAST  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_RESET = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OUTSIDE  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_NO_REPAIR = 2'd3;

  localparam logic CFG_BLOCK_SIZE = 1'b0;
  localparam logic CFG_DEPTH      = 1'b1;

  localparam int LEN_W = 12;
  localparam logic [LEN_W-1:0] LEN_MAX = 12'd4095;

  // Byte lanes of word w lying below byte length len.
  function automatic logic [63:0] lanes_below(input logic [12:0] w8, input logic [11:0] len);
    logic [63:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if ((w8 + 13'(k)) < {1'b0, len}) m[8*k +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic [63:0] data_mask(input logic [3:0] nb);
    logic [63:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < nb) m[8*k +: 8] = 8'hFF;
    end
    return m;
  endfunction

  // x mod d for d in 1..8 via a scaled reciprocal; exact for x below 64.
  function automatic logic [2:0] mod_depth(input logic [5:0] x, input logic [3:0] d);
    logic [10:0] recip;
    logic [16:0] prod;
    logic [5:0]  quo;
    logic [9:0]  back;
    logic [5:0]  rem;
    case (d)
      4'd1: recip = 11'd1024;
      4'd2: recip = 11'd512;
      4'd3: recip = 11'd342;
      4'd4: recip = 11'd256;
      4'd5: recip = 11'd205;
      4'd6: recip = 11'd171;
      4'd7: recip = 11'd147;
      default: recip = 11'd128;
    endcase
    prod = 17'(x) * 17'(recip);
    quo = prod[15:10];
    back = 10'(quo) * 10'(d);
    rem = x - back[5:0];
    return rem[2:0];
  endfunction
endpackage

// ===== src/ixfec_ram.sv =====
module ixfec_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/ixfec_lane.sv =====
// One coding unit: parity store, recipe list, length and fill.
module ixfec_lane import ixfec_pkg::*; #(
  parameter int MAX_BLOCK    = 64,
  parameter int PACKET_WORDS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clr,
  // stage 0: issue reads
  input  logic [$clog2(PACKET_WORDS)-1:0] rd_word,
  input  logic [$clog2(MAX_BLOCK)-1:0]    rd_recipe,
  // stage 1: parity write and recipe append
  input  logic                            wr_en,
  input  logic [$clog2(PACKET_WORDS)-1:0] wr_word,
  input  logic [63:0]                     wr_data,
  input  logic [3:0]                      wr_nb,
  input  logic                            rec_en,
  input  logic [31:0]                     rec_psn,
  output logic [63:0]                     par_rdata,
  output logic [31:0]                     rec_rdata,
  output logic [LEN_W-1:0]                len_o,
  output logic [$clog2(MAX_BLOCK+1)-1:0]  fill_o
);
  localparam int RW = $clog2(MAX_BLOCK);
  localparam int FW = $clog2(MAX_BLOCK + 1);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [63:0]      par_w;
  logic [13:0]      end_b;
  logic             rec_we;

  always_comb begin
    end_b = {wr_word, 3'b000} + 14'(wr_nb);
    par_w = (par_rdata & lanes_below(13'({wr_word, 3'b000}), len_r))
            ^ (wr_data & data_mask(wr_nb));
    len_nxt = len_r;
    if (wr_en) begin
      if (end_b > 14'(LEN_MAX)) begin
        if (LEN_MAX > len_r) len_nxt = LEN_MAX;
      end else if (end_b[LEN_W-1:0] > len_r) begin
        len_nxt = end_b[LEN_W-1:0];
      end
    end
    rec_we = rec_en && (fill_r < FW'(MAX_BLOCK));
    fill_nxt = rec_we ? fill_r + FW'(1) : fill_r;
    if (clr) begin
      len_nxt  = '0;
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      fill_r <= '0;
    end else begin
      len_r  <= len_nxt;
      fill_r <= fill_nxt;
    end
  end

  ixfec_ram #(.WIDTH(64), .DEPTH(PACKET_WORDS)) u_par (
    .clk(clk), .we(wr_en), .waddr(wr_word), .wdata(par_w),
    .raddr(rd_word), .rdata(par_rdata)
  );

  ixfec_ram #(.WIDTH(32), .DEPTH(MAX_BLOCK)) u_rec (
    .clk(clk), .we(rec_we), .waddr(fill_r[RW-1:0]), .wdata(rec_psn),
    .raddr(rd_recipe), .rdata(rec_rdata)
  );

  assign len_o  = len_r;
  assign fill_o = fill_r;
endmodule

// ===== src/interleaved_xor_fec_encoder.sv =====
// channel | ports                          | handshake
// in      | in_func .. in_last_length_in   | in_valid / in_ready
// out     | out_status .. out_block_complete | out_valid / out_ready
// cfg     | cfg_we, cfg_index, cfg_data    | write on cfg_we
// Each word is handled by reading the lane memories, then updating state and
// registering the result (read-modify-write of the parity store).
// One word is in flight at a time; a held result stalls the next word.
// Reset is synchronous; memories are not cleared.
module interleaved_xor_fec_encoder import ixfec_pkg::*; #(
  parameter int MAX_BLOCK    = 64,
  parameter int UNITS        = 8,
  parameter int PACKET_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_psn,
  input  logic [63:0] in_data,
  input  logic [7:0]  in_word_index,
  input  logic [3:0]  in_bytes_valid,
  input  logic        in_end_of_packet,
  input  logic [2:0]  in_unit_sel,
  input  logic        in_allow_incomplete,
  input  logic [15:0] in_last_rel_in,
  input  logic [15:0] in_last_length_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_parity_word,
  output logic [11:0] out_unit_length,
  output logic [6:0]  out_recipe_count,
  output logic [31:0] out_recipe_psn,
  output logic [31:0] out_base_psn,
  output logic        out_has_first,
  output logic        out_has_last,
  output logic [15:0] out_last_rel,
  output logic [15:0] out_last_length,
  output logic [6:0]  out_packet_count,
  output logic        out_block_complete
);
  localparam int WW = $clog2(PACKET_WORDS);
  localparam int RW = $clog2(MAX_BLOCK);
  localparam int FW = $clog2(MAX_BLOCK + 1);
  localparam int UW = (UNITS > 1) ? $clog2(UNITS) : 1;

  logic [6:0] bsize_r;
  logic [3:0] depth_r;

  // held item
  logic        busy_r;
  logic [1:0]  func_r;
  logic [31:0] psn_r;
  logic [63:0] data_r;
  logic [7:0]  widx_r;
  logic [3:0]  nb_r;
  logic        eop_r, allow_r;
  logic [2:0]  usel_r;
  logic [15:0] lrel_in_r, llen_in_r;

  logic [31:0] base_r, base_nxt;
  logic [6:0]  pkts_r, pkts_nxt;
  logic        first_r, first_nxt, lastf_r, lastf_nxt;
  logic [15:0] lrel_r, lrel_nxt, llen_r, llen_nxt;
  logic [UW-1:0] ounit_r, ounit_nxt;
  logic        ook_r, ook_nxt;

  logic [6:0]  eff_blk;
  logic [3:0]  eff_dep;
  logic        accept, done;

  always_comb begin
    eff_blk = (32'(bsize_r) > 32'(MAX_BLOCK)) ? 7'(MAX_BLOCK) : bsize_r;
    if (depth_r == 4'd0) eff_dep = 4'd1;
    else if (32'(depth_r) > 32'(UNITS)) eff_dep = 4'(UNITS);
    else eff_dep = depth_r;
  end

  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  assign done     = busy_r && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsize_r <= 7'd64;
      depth_r <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_SIZE: bsize_r <= cfg_data;
        CFG_DEPTH:      depth_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func; psn_r <= in_psn; data_r <= in_data;
      widx_r <= in_word_index;
      nb_r <= (in_bytes_valid > 4'd8) ? 4'd8 : in_bytes_valid;
      eop_r <= in_end_of_packet; usel_r <= in_unit_sel;
      allow_r <= in_allow_incomplete;
      lrel_in_r <= in_last_rel_in; llen_in_r <= in_last_length_in;
    end
  end

  // lane signals
  logic [63:0]      par_rd  [UNITS];
  logic [31:0]      rec_rd  [UNITS];
  logic [LEN_W-1:0] len_l   [UNITS];
  logic [FW-1:0]    fill_l  [UNITS];
  logic [UNITS-1:0] wr_en_l, rec_en_l;

  // keep re-reading the held word's address so a stalled result sees its data
  logic [WW-1:0] rd_word;
  logic [RW-1:0] rd_rec;
  assign rd_word = busy_r ? WW'(widx_r) : WW'(in_word_index);
  assign rd_rec  = busy_r ? RW'(widx_r) : RW'(in_word_index);

  // step computation (valid on the held item once RAM data is back)
  logic [31:0] base_s, rel;
  logic        opened, inblk;
  logic [3:0]  rel_mod;
  logic        is_start, wr_ok, clr;
  logic [1:0]  st;
  logic        word_big, read_bad, usel_ok;
  logic [UW-1:0] usel_u;
  logic [63:0] pword;
  logic [11:0] ulen;
  logic [6:0]  rcount;
  logic [31:0] rpsn;

  always_comb begin
    base_nxt = base_r; pkts_nxt = pkts_r; first_nxt = first_r; lastf_nxt = lastf_r;
    lrel_nxt = lrel_r; llen_nxt = llen_r; ounit_nxt = ounit_r; ook_nxt = ook_r;
    wr_en_l = '0; rec_en_l = '0; clr = 1'b0; st = ST_OK;
    pword = '0; ulen = '0; rcount = '0; rpsn = '0;
    is_start = (func_r == FUNC_DATA) && (widx_r == 8'd0);
    opened = is_start && (pkts_r == 7'd0);
    base_s = opened ? psn_r : base_r;
    rel = psn_r - base_s;
    inblk = rel < 32'(eff_blk);
    // rel is below 64 whenever the packet is inside the block
    rel_mod = {1'b0, mod_depth(rel[5:0], eff_dep)};
    word_big = 32'(widx_r) >= 32'(PACKET_WORDS);
    usel_ok = (32'(usel_r) < 32'(eff_dep)) && (32'(usel_r) < 32'(UNITS));
    usel_u = UW'(usel_r);
    wr_ok = 1'b0;
    read_bad = 1'b0;
    if (done) begin
      case (func_r)
        FUNC_DATA: begin
          if (opened) begin
            base_nxt = psn_r; first_nxt = (psn_r == 32'd0);
            lastf_nxt = 1'b0; lrel_nxt = '0; llen_nxt = '0;
          end
          if (is_start) begin
            if (!inblk) ook_nxt = 1'b0;
            else begin
              ounit_nxt = UW'(rel_mod);
              ook_nxt = 1'b1;
              rec_en_l[UW'(rel_mod)] = 1'b1;
              if (pkts_r < 7'd127) pkts_nxt = pkts_r + 7'd1;
            end
          end
          if (!ook_nxt) st = ST_OUTSIDE;
          else if (word_big) st = ST_OVERFLOW;
          else begin
            wr_ok = 1'b1;
            wr_en_l[ounit_nxt] = 1'b1;
          end
          if (eop_r) ook_nxt = 1'b0;
        end
        FUNC_LAST: begin
          lastf_nxt = 1'b1; lrel_nxt = lrel_in_r; llen_nxt = llen_in_r;
        end
        FUNC_READ: begin
          read_bad = (!allow_r && !(pkts_r >= eff_blk)) || (allow_r && pkts_r == 7'd0)
                     || !usel_ok;
          if (!read_bad && fill_l[usel_u] == '0) read_bad = 1'b1;
          if (read_bad) st = ST_NO_REPAIR;
          else begin
            ulen = len_l[usel_u];
            rcount = 7'(fill_l[usel_u]);
            if (!word_big)
              pword = par_rd[usel_u] & lanes_below(13'({widx_r, 3'b000}), len_l[usel_u]);
            if ((32'(widx_r) < 32'(fill_l[usel_u])) && (32'(widx_r) < 32'(MAX_BLOCK)))
              rpsn = rec_rd[usel_u];
          end
        end
        default: begin
          base_nxt = base_r + 32'(eff_blk);
          pkts_nxt = '0; first_nxt = 1'b0; lastf_nxt = 1'b0;
          lrel_nxt = '0; llen_nxt = '0; ook_nxt = 1'b0; clr = 1'b1;
        end
      endcase
    end
  end

  for (genvar g = 0; g < UNITS; g++) begin : g_lane
    ixfec_lane #(.MAX_BLOCK(MAX_BLOCK), .PACKET_WORDS(PACKET_WORDS)) u_lane (
      .clk(clk), .rst_n(rst_n), .clr(clr),
      .rd_word(rd_word), .rd_recipe(rd_rec),
      .wr_en(wr_en_l[g] && wr_ok), .wr_word(WW'(widx_r)), .wr_data(data_r), .wr_nb(nb_r),
      .rec_en(rec_en_l[g]), .rec_psn(psn_r),
      .par_rdata(par_rd[g]), .rec_rdata(rec_rd[g]),
      .len_o(len_l[g]), .fill_o(fill_l[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; out_valid <= 1'b0;
      base_r <= '0; pkts_r <= '0; first_r <= 1'b0; lastf_r <= 1'b0;
      lrel_r <= '0; llen_r <= '0; ounit_r <= '0; ook_r <= 1'b0;
    end else begin
      base_r <= base_nxt; pkts_r <= pkts_nxt; first_r <= first_nxt; lastf_r <= lastf_nxt;
      lrel_r <= lrel_nxt; llen_r <= llen_nxt; ounit_r <= ounit_nxt; ook_r <= ook_nxt;
      if (accept) busy_r <= 1'b1;
      else if (done) busy_r <= 1'b0;
      if (done) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // merged result word
  always_ff @(posedge clk) begin
    if (done) begin
      out_status <= st; out_parity_word <= pword; out_unit_length <= ulen;
      out_recipe_count <= rcount; out_recipe_psn <= rpsn;
      out_base_psn <= base_nxt; out_has_first <= first_nxt; out_has_last <= lastf_nxt;
      out_last_rel <= lrel_nxt; out_last_length <= llen_nxt;
      out_packet_count <= pkts_nxt; out_block_complete <= pkts_nxt >= eff_blk;
    end
  end
endmodule
